@@ sv/mtc_pkg.sv @@
// mtc_pkg: payload structs and code definitions for the matrix-multiply tile.
// No dependencies; imported by matmul_tile_cascade, mtc_tile_checker and tb.
`default_nettype none

package mtc_pkg;

    // Input item kinds
    typedef enum logic [2:0] {
        KIND_LOAD_A  = 3'd0,
        KIND_LOAD_B  = 3'd1,
        KIND_LOAD_C  = 3'd2,
        KIND_COMPUTE = 3'd3,
        KIND_READ_C  = 3'd4
    } kind_t;

    // Cascade modes held in the configuration register
    typedef enum logic [1:0] {
        MODE_PRODUCT = 2'd0,
        MODE_ACCUM   = 2'd1,
        MODE_CASCADE = 2'd2
    } mode_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAC,
        ST_DRAIN,
        ST_CASC,
        ST_CADD,
        ST_READ,
        ST_OUT
    } state_t;

    // Input beat
    typedef struct packed {
        logic [2:0]         kind;
        logic [7:0]         index;
        logic signed [15:0] operand_value;
        logic signed [31:0] acc_value;
        logic signed [31:0] cascade_in;
    } in_item_t;

    // Result beat
    typedef struct packed {
        logic signed [31:0] result_value;
        logic [3:0]         out_row;
        logic [3:0]         out_col;
        logic               last_of_tile;
    } out_item_t;

endpackage

`default_nettype wire

@@ sv/mtc_ram.sv @@
// mtc_ram: generic single-write, single-read RAM with registered read data.
// No dependencies; used for the A, B and C stores of the tile.
`default_nettype none

module mtc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // Registered read port; data holds between reads
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

@@ sv/matmul_tile_cascade.sv @@
// matmul_tile_cascade: integer matrix-multiply tile with partial-sum cascade.
// Depends on mtc_pkg (types, codes) and mtc_ram (A, B, C stores).
//
//  channel | direction | handshake            | beat
//  --------+-----------+----------------------+-------------------------------
//  in      | to block  | in_valid / in_stall  | in_item_t: load, compute, read
//  out     | from block| out_valid / out_stall| out_item_t: one result
//  cfg     | to block  | cfg_valid / cfg_ready| cfg_data: cascade mode
//
// Each in-range load is one RAM write. A compute beat runs one multiply-accumulate per cycle
// through the shared MAC, a drain of the RAM-read and product registers, the cascade
// add (accumulate and cascade modes) and the C add (accumulate mode) in the same
// adder, then the output register load. A read of C goes through the RAM read,
// the row split by a reciprocal multiply, then the output register load.
// Reset clears the sequencer, the position and the mode; the stores are not cleared.
// A stalled result sits in the output register; the block takes the next beat
// meanwhile and only waits at the end of that beat if the register is still full.
`default_nettype none

module matmul_tile_cascade #(
    parameter int ROWS  = 16,
    parameter int INNER = 16,
    parameter int COLS  = 16
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire mtc_pkg::in_item_t  in_data,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output mtc_pkg::out_item_t      out_data,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [1:0]         cfg_data
);

    import mtc_pkg::*;

    localparam int A_DEPTH = ROWS * INNER;
    localparam int B_DEPTH = INNER * COLS;
    localparam int C_DEPTH = ROWS * COLS;
    localparam int A_AW    = (A_DEPTH > 1) ? $clog2(A_DEPTH) : 1;
    localparam int B_AW    = (B_DEPTH > 1) ? $clog2(B_DEPTH) : 1;
    localparam int C_AW    = (C_DEPTH > 1) ? $clog2(C_DEPTH) : 1;
    localparam int RW      = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int CW      = (COLS > 1) ? $clog2(COLS) : 1;
    localparam int KW      = (INNER > 1) ? $clog2(INNER) : 1;
    // ceil(2^16 / COLS): exact row split for an 8-bit index while COLS < 256
    localparam int RECIP   = (65536 + COLS - 1) / COLS;

    // Sequencer and datapath registers
    state_t             state_reg, state_next;
    logic [1:0]         mode_reg;
    logic signed [31:0] acc_reg, acc_next;
    logic signed [31:0] prod_reg;
    logic               rd_vld_reg, prod_vld_reg;
    logic [KW-1:0]      k_reg;
    logic [A_AW-1:0]    a_base_reg;
    logic [B_AW-1:0]    b_addr_reg;
    logic [RW-1:0]      row_reg;
    logic [CW-1:0]      col_reg;
    logic [C_AW-1:0]    c_addr_reg;
    logic signed [31:0] casc_reg;
    logic               is_read_reg;
    logic               range_ok_reg;
    logic [7:0]         idx_reg;
    logic [7:0]         rd_row_reg;
    logic               out_valid_reg;
    out_item_t          out_data_reg;

    // RAM ports
    logic               a_wr_en, b_wr_en, c_wr_en;
    logic               a_rd_en, b_rd_en, c_rd_en;
    logic [A_AW-1:0]    a_rd_addr;
    logic [C_AW-1:0]    c_wr_addr, c_rd_addr;
    logic [31:0]        c_wr_data;
    logic [15:0]        a_rd_data, b_rd_data;
    logic [31:0]        c_rd_data;

    // Control
    logic               in_acc;
    logic               out_load;
    logic               drain_done;
    logic               k_last;
    logic               at_last;
    logic signed [31:0] addend;
    logic signed [31:0] sum;
    logic [23:0]        recip_prod;
    logic [7:0]         rd_col;

    assign in_acc     = in_valid && !in_stall;
    assign in_stall   = (state_reg != ST_IDLE);
    assign cfg_ready  = (state_reg == ST_IDLE);
    assign out_valid  = out_valid_reg;
    assign out_data   = out_data_reg;
    assign drain_done = !rd_vld_reg && !prod_vld_reg;
    assign k_last     = (k_reg == KW'(INNER - 1));
    assign at_last    = (row_reg == RW'(ROWS - 1)) && (col_reg == CW'(COLS - 1));
    assign a_rd_addr  = A_AW'(a_base_reg + A_AW'(k_reg));

    // Shared accumulator adder
    assign sum = acc_reg + addend;

    // Read index split: row by reciprocal multiply, column by the remainder
    assign recip_prod = 24'(idx_reg) * 24'(RECIP);
    assign rd_col     = idx_reg - 8'(16'(rd_row_reg) * 16'(COLS));

    // Stores
    mtc_ram #(.WIDTH(16), .DEPTH(A_DEPTH)) u_a_ram (
        .clk     (clk),
        .wr_en   (a_wr_en),
        .wr_addr (A_AW'(in_data.index)),
        .wr_data (in_data.operand_value),
        .rd_en   (a_rd_en),
        .rd_addr (a_rd_addr),
        .rd_data (a_rd_data)
    );

    mtc_ram #(.WIDTH(16), .DEPTH(B_DEPTH)) u_b_ram (
        .clk     (clk),
        .wr_en   (b_wr_en),
        .wr_addr (B_AW'(in_data.index)),
        .wr_data (in_data.operand_value),
        .rd_en   (b_rd_en),
        .rd_addr (b_addr_reg),
        .rd_data (b_rd_data)
    );

    mtc_ram #(.WIDTH(32), .DEPTH(C_DEPTH)) u_c_ram (
        .clk     (clk),
        .wr_en   (c_wr_en),
        .wr_addr (c_wr_addr),
        .wr_data (c_wr_data),
        .rd_en   (c_rd_en),
        .rd_addr (c_rd_addr),
        .rd_data (c_rd_data)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc && in_data.kind == KIND_COMPUTE)
                begin
                    state_next = ST_MAC;
                end
                else if (in_acc && in_data.kind == KIND_READ_C)
                begin
                    state_next = ST_READ;
                end
            end
            ST_MAC:
            begin
                if (k_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (drain_done)
                begin
                    state_next = ST_CASC;
                end
            end
            ST_CASC:  state_next = ST_CADD;
            ST_CADD:  state_next = ST_OUT;
            ST_READ:  state_next = ST_OUT;
            ST_OUT:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // Outputs of the sequencer: RAM controls, adder operand, accumulator, output register load
    always_comb
    begin
        a_wr_en   = 1'b0;
        b_wr_en   = 1'b0;
        c_wr_en   = 1'b0;
        a_rd_en   = 1'b0;
        b_rd_en   = 1'b0;
        c_rd_en   = 1'b0;
        c_wr_addr = C_AW'(in_data.index);
        c_wr_data = in_data.acc_value;
        c_rd_addr = c_addr_reg;
        addend    = '0;
        acc_next  = acc_reg;
        out_load  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    unique case (in_data.kind)
                        KIND_LOAD_A:  a_wr_en = (32'(in_data.index) < 32'(A_DEPTH));
                        KIND_LOAD_B:  b_wr_en = (32'(in_data.index) < 32'(B_DEPTH));
                        KIND_LOAD_C:  c_wr_en = (32'(in_data.index) < 32'(C_DEPTH));
                        KIND_COMPUTE: acc_next = '0;
                        KIND_READ_C:
                        begin
                            c_rd_en   = (32'(in_data.index) < 32'(C_DEPTH));
                            c_rd_addr = C_AW'(in_data.index);
                        end
                        default: ;
                    endcase
                end
            end
            ST_MAC, ST_DRAIN:
            begin
                a_rd_en = (state_reg == ST_MAC);
                b_rd_en = (state_reg == ST_MAC);
                if (prod_vld_reg)
                begin
                    addend   = prod_reg;
                    acc_next = sum;
                end
                // fetch C once the dot product has settled
                c_rd_en = (state_reg == ST_DRAIN) && drain_done;
            end
            ST_CASC:
            begin
                if (mode_reg == MODE_ACCUM || mode_reg == MODE_CASCADE)
                begin
                    addend = casc_reg;
                end
                acc_next = sum;
            end
            ST_CADD:
            begin
                if (mode_reg == MODE_ACCUM)
                begin
                    addend    = c_rd_data;
                    c_wr_en   = 1'b1;
                    c_wr_addr = c_addr_reg;
                    c_wr_data = sum;
                end
                acc_next = sum;
            end
            ST_READ:
            begin
                // read data lands here
                acc_next = range_ok_reg ? c_rd_data : '0;
            end
            ST_OUT:   out_load = !out_valid_reg || !out_stall;
            default: ;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mode_reg      <= MODE_PRODUCT;
            rd_vld_reg    <= 1'b0;
            prod_vld_reg  <= 1'b0;
            row_reg       <= '0;
            col_reg       <= '0;
            a_base_reg    <= '0;
            c_addr_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            rd_vld_reg   <= (state_reg == ST_MAC);
            prod_vld_reg <= rd_vld_reg;

            if (cfg_valid && cfg_ready)
            begin
                mode_reg <= cfg_data;
            end

            // output register: reload or drain
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            // advance the tile position after each compute result
            if (out_load && !is_read_reg)
            begin
                if (col_reg == CW'(COLS - 1))
                begin
                    col_reg <= '0;
                    if (row_reg == RW'(ROWS - 1))
                    begin
                        row_reg    <= '0;
                        a_base_reg <= '0;
                    end
                    else
                    begin
                        row_reg    <= RW'(row_reg + 1'b1);
                        a_base_reg <= A_AW'(a_base_reg + A_AW'(INNER));
                    end
                end
                else
                begin
                    col_reg <= CW'(col_reg + 1'b1);
                end
                c_addr_reg <= at_last ? '0 : C_AW'(c_addr_reg + 1'b1);
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        acc_reg  <= acc_next;
        prod_reg <= $signed(a_rd_data) * $signed(b_rd_data);

        if (state_reg == ST_IDLE && in_acc)
        begin
            k_reg        <= '0;
            b_addr_reg   <= B_AW'(col_reg);
            casc_reg     <= in_data.cascade_in;
            is_read_reg  <= (in_data.kind == KIND_READ_C);
            range_ok_reg <= (32'(in_data.index) < 32'(C_DEPTH));
            idx_reg      <= in_data.index;
        end

        // step the inner index and walk down the B column
        if (state_reg == ST_MAC)
        begin
            k_reg      <= KW'(k_reg + 1'b1);
            b_addr_reg <= B_AW'(b_addr_reg + B_AW'(COLS));
        end

        if (state_reg == ST_READ)
        begin
            rd_row_reg <= recip_prod[23:16];
        end

        // result beat
        if (out_load)
        begin
            out_data_reg.result_value <= acc_reg;
            if (is_read_reg)
            begin
                out_data_reg.out_row      <= range_ok_reg ? rd_row_reg[3:0] : 4'd0;
                out_data_reg.out_col      <= range_ok_reg ? rd_col[3:0] : 4'd0;
                out_data_reg.last_of_tile <= 1'b0;
            end
            else
            begin
                out_data_reg.out_row      <= 4'(row_reg);
                out_data_reg.out_col      <= 4'(col_reg);
                out_data_reg.last_of_tile <= at_last;
            end
        end
    end

    // MAC pipeline only runs while a compute beat is in flight
    assert property (@(posedge clk) disable iff (!rst_n)
        rd_vld_reg |-> (state_reg == ST_MAC || state_reg == ST_DRAIN))
        else $error("MAC read pipeline active outside compute");

    // C is written by loads, or by the accumulate step in accumulate mode only
    assert property (@(posedge clk) disable iff (!rst_n)
        c_wr_en |-> (state_reg == ST_IDLE ||
                     (state_reg == ST_CADD && mode_reg == MODE_ACCUM)))
        else $error("unexpected C store write");

    // a result appears only from the output state
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == ST_OUT)
        else $error("result raised outside output state");

    // tile position stays inside the tile
    assert property (@(posedge clk) disable iff (!rst_n)
        (col_reg <= CW'(COLS - 1)) && (row_reg <= RW'(ROWS - 1)))
        else $error("tile position out of range");

    // compute beats leave the position alone until their result is loaded; checked during the dot product
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MAC) |=> $stable(col_reg) && $stable(row_reg))
        else $error("position moved during dot product");

endmodule

`default_nettype wire

@@ verif/mtc_tile_checker.sv @@
// mtc_tile_checker: watches the in, out and cfg channels of the matrix-multiply tile,
// predicts every result beat from its own copy of the stores and position, compares.
// Depends on mtc_pkg for the beat structs, kinds and modes.
`timescale 1ns / 1ps

module mtc_tile_checker #(
    parameter int ROWS  = 16,
    parameter int INNER = 16,
    parameter int COLS  = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  mtc_pkg::in_item_t  in_data,
    input  logic               out_valid,
    input  logic               out_stall,
    input  mtc_pkg::out_item_t out_data,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [1:0]         cfg_data,
    output int                 fail_count,
    output int                 pending
);

    import mtc_pkg::*;

    localparam int A_SIZE = ROWS * INNER;
    localparam int B_SIZE = INNER * COLS;
    localparam int C_SIZE = ROWS * COLS;

    // shadow copy of the tile state
    logic signed [15:0] a_mem [A_SIZE];
    logic signed [15:0] b_mem [B_SIZE];
    logic [31:0]        c_mem [C_SIZE];
    int                 row_pos;
    int                 col_pos;
    logic [1:0]         mode_reg;

    out_item_t          expected_beats [$];
    int                 errors;

    // dot product of A row r and B column c, 32-bit wrapping
    function automatic logic [31:0] row_col_dot(int r, int c);
        logic [31:0]        sum;
        logic signed [31:0] prod;
        sum = '0;
        for (int i = 0; i < INNER; i++)
        begin
            prod = a_mem[r * INNER + i] * b_mem[i * COLS + c];
            sum  = sum + prod;
        end
        return sum;
    endfunction

    // update the shadow state for one input beat, queue its result if any
    task automatic predict_beat(input in_item_t it);
        out_item_t   res;
        int          idx;
        logic [31:0] sum;
        idx = it.index;
        res = '0;
        case (it.kind)
            KIND_LOAD_A: if (idx < A_SIZE) a_mem[idx] = it.operand_value;
            KIND_LOAD_B: if (idx < B_SIZE) b_mem[idx] = it.operand_value;
            KIND_LOAD_C: if (idx < C_SIZE) c_mem[idx] = it.acc_value;
            KIND_COMPUTE:
            begin
                sum = row_col_dot(row_pos, col_pos);
                if (mode_reg == MODE_ACCUM)
                begin
                    c_mem[row_pos * COLS + col_pos] =
                        c_mem[row_pos * COLS + col_pos] + sum + it.cascade_in;
                    sum = c_mem[row_pos * COLS + col_pos];
                end
                else if (mode_reg == MODE_CASCADE)
                begin
                    sum = sum + it.cascade_in;
                end
                res.result_value = sum;
                res.out_row      = row_pos[3:0];
                res.out_col      = col_pos[3:0];
                res.last_of_tile = (row_pos == ROWS - 1) && (col_pos == COLS - 1);
                expected_beats.push_back(res);
                // step row-major, wrap at end of tile
                col_pos++;
                if (col_pos >= COLS)
                begin
                    col_pos = 0;
                    row_pos++;
                    if (row_pos >= ROWS)
                        row_pos = 0;
                end
            end
            KIND_READ_C:
            begin
                if (idx < C_SIZE)
                begin
                    res.result_value = c_mem[idx];
                    res.out_row      = 4'(idx / COLS);
                    res.out_col      = 4'(idx % COLS);
                end
                expected_beats.push_back(res);
            end
            default: ;
        endcase
    endtask

    // compare one result beat against the oldest expectation
    task automatic check_beat(input out_item_t got);
        out_item_t exp_beat;
        if (expected_beats.size() == 0)
        begin
            $display("%0t: unexpected result beat, value %0d row %0d col %0d",
                     $time, got.result_value, got.out_row, got.out_col);
            errors++;
        end
        else
        begin
            exp_beat = expected_beats.pop_front();
            if (got.result_value !== exp_beat.result_value)
            begin
                $display("%0t: result_value expected %0d, got %0d",
                         $time, exp_beat.result_value, got.result_value);
                errors++;
            end
            if (got.out_row !== exp_beat.out_row)
            begin
                $display("%0t: out_row expected %0d, got %0d",
                         $time, exp_beat.out_row, got.out_row);
                errors++;
            end
            if (got.out_col !== exp_beat.out_col)
            begin
                $display("%0t: out_col expected %0d, got %0d",
                         $time, exp_beat.out_col, got.out_col);
                errors++;
            end
            if (got.last_of_tile !== exp_beat.last_of_tile)
            begin
                $display("%0t: last_of_tile expected %0d, got %0d",
                         $time, exp_beat.last_of_tile, got.last_of_tile);
                errors++;
            end
        end
    endtask

    // sample all channels at the clock edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_pos  = 0;
            col_pos  = 0;
            mode_reg = MODE_PRODUCT;
            errors   = 0;
            expected_beats.delete();
            fail_count <= 0;
            pending    <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                mode_reg = cfg_data;
            if (in_valid && !in_stall)
                predict_beat(in_data);
            if (out_valid && !out_stall)
                check_beat(out_data);
            fail_count <= errors;
            pending    <= expected_beats.size();
        end
    end

endmodule

@@ verif/tb.sv @@
// tb: stimulus and verdict for matmul_tile_cascade; fills the stores, runs directed
// beats, then random phases under each cascade mode. Needs mtc_pkg, the block, mtc_tile_checker.
`timescale 1ns / 1ps

module tb;
    import mtc_pkg::*;

    localparam int ROWS  = 16;
    localparam int INNER = 16;
    localparam int COLS  = 16;

    localparam logic [2:0] KIND_SPARE_FIRST = 3'd5;
    localparam logic [2:0] KIND_SPARE_MID   = 3'd6;
    localparam logic [2:0] KIND_SPARE_LAST  = 3'd7;
    localparam logic [1:0] MODE_SPARE       = 2'd3;

    localparam int PHASE_BEATS  = 40;
    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT  = 800000;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_stall;
    in_item_t   in_data   = '0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    out_item_t  out_data;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [1:0] cfg_data  = '0;

    int          fail_count;
    int          pending;
    int          burst_left  = 0;
    logic [7:0]  tile_pos    = '0;
    int unsigned cycle_count = 0;

    matmul_tile_cascade #(
        .ROWS  (ROWS),
        .INNER (INNER),
        .COLS  (COLS)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    mtc_tile_checker #(
        .ROWS  (ROWS),
        .INNER (INNER),
        .COLS  (COLS)
    ) i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // clock
    initial
    begin
        forever #5 clk = ~clk;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // receiver stall: the style (none, random, fixed pattern or random runs) is redrawn at random
    always @(posedge clk)
    begin : stall_gen
        int  style;
        int  run_left;
        bit  run_stalled;
        bit  s;
        if (cycle_count % 150 == 0)
            style = $urandom_range(0, 3);
        case (style)
            0: s = 1'b0;
            1: s = $urandom_range(0, 1);
            2: s = (cycle_count % 5) < 2;
            default:
            begin
                if (run_left <= 0)
                begin
                    run_stalled = ~run_stalled;
                    run_left    = $urandom_range(1, 30);
                end
                run_left--;
                s = run_stalled;
            end
        endcase
        out_stall <= s;
    end

    function automatic logic signed [15:0] pick_operand();
        case ($urandom_range(0, 7))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return -16'sd1;
            3: return 16'sd0;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic signed [31:0] pick_wide();
        case ($urandom_range(0, 7))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2: return -32'sd1;
            3: return 32'sd0;
            default: return 32'($urandom);
        endcase
    endfunction

    // one input beat; the sender runs in bursts with random gaps between them
    task automatic put_beat(input in_item_t it);
        int gap;
        if (burst_left <= 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 30) : $urandom_range(0, 3);
            if ($urandom_range(0, 7) == 0)
                gap = 0;
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do @(posedge clk); while (in_stall);
        if (it.kind == KIND_COMPUTE)
            tile_pos++;
        burst_left--;
    endtask

    task automatic put_fields(input logic [2:0] kind, input int idx,
                              input logic signed [15:0] opnd,
                              input logic signed [31:0] acc,
                              input logic signed [31:0] casc);
        in_item_t it;
        it.kind          = kind;
        it.index         = 8'(idx);
        it.operand_value = opnd;
        it.acc_value     = acc;
        it.cascade_in    = casc;
        put_beat(it);
    endtask

    // wait until every result is out and the block has settled
    task automatic drain();
        in_valid <= 1'b0;
        burst_left = 0;
        do @(posedge clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_mode(input logic [1:0] mode);
        cfg_valid <= 1'b1;
        cfg_data  <= mode;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // random beat; spare kinds are ignored by the block and not counted
    task automatic random_beat(output bit counted);
        in_item_t it;
        int       pick;
        pick = $urandom_range(0, 99);
        it.index         = 8'($urandom_range(0, 255));
        it.operand_value = pick_operand();
        it.acc_value     = pick_wide();
        it.cascade_in    = pick_wide();
        counted          = 1'b1;
        if (pick < 40)
            it.kind = KIND_COMPUTE;
        else if (pick < 52)
            it.kind = KIND_LOAD_A;
        else if (pick < 64)
            it.kind = KIND_LOAD_B;
        else if (pick < 75)
            it.kind = KIND_LOAD_C;
        else if (pick < 95)
            it.kind = KIND_READ_C;
        else
        begin
            it.kind = 3'($urandom_range(KIND_SPARE_FIRST, KIND_SPARE_LAST));
            counted = 1'b0;
        end
        put_beat(it);
    endtask

    initial
    begin : stimulus
        logic [1:0] phase_modes [6];
        bit         counted;
        int         n;
        phase_modes = '{MODE_CASCADE, MODE_ACCUM, MODE_PRODUCT, MODE_SPARE,
                        MODE_ACCUM, MODE_PRODUCT};

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // fill every store entry; A row 0 and B columns 0 and COLS-1 at the negative extreme
        for (int i = 0; i < ROWS * INNER; i++)
            put_fields(KIND_LOAD_A, i,
                       (i / INNER == 0) ? 16'sh8000 :
                       (i / INNER == ROWS - 1) ? 16'sh7fff : pick_operand(),
                       pick_wide(), pick_wide());
        for (int i = 0; i < INNER * COLS; i++)
            put_fields(KIND_LOAD_B, i,
                       (i % COLS == 0 || i % COLS == COLS - 1) ? 16'sh8000 : pick_operand(),
                       pick_wide(), pick_wide());
        for (int i = 0; i < ROWS * COLS; i++)
            put_fields(KIND_LOAD_C, i, pick_operand(), pick_wide(), pick_wide());

        // directed: C extremes, read back, spare kinds, computes in each mode
        put_fields(KIND_LOAD_C, 0, 16'sd0, 32'sh7fff_ffff, 32'sd0);
        put_fields(KIND_LOAD_C, ROWS * COLS - 1, 16'sd0, 32'sh8000_0000, 32'sd0);
        put_fields(KIND_READ_C, 0, 16'sd0, 32'sd0, 32'sd0);
        put_fields(KIND_READ_C, ROWS * COLS - 1, -16'sd1, -32'sd1, -32'sd1);
        put_fields(KIND_SPARE_FIRST, 255, -16'sd1, -32'sd1, -32'sd1);
        put_fields(KIND_SPARE_MID, 0, 16'sd0, 32'sd0, 32'sd0);
        put_fields(KIND_SPARE_LAST, 17, 16'sh7fff, 32'sh7fff_ffff, 32'sh8000_0000);
        put_fields(KIND_COMPUTE, 0, 16'sd0, 32'sd0, 32'sh7fff_ffff);
        put_fields(KIND_COMPUTE, 0, 16'sd0, 32'sd0, 32'sd0);
        drain();
        write_mode(MODE_CASCADE);
        put_fields(KIND_COMPUTE, 0, 16'sd0, 32'sd0, 32'sh7fff_ffff);
        put_fields(KIND_COMPUTE, 255, -16'sd1, -32'sd1, 32'sh8000_0000);
        drain();
        write_mode(MODE_ACCUM);
        put_fields(KIND_COMPUTE, 0, 16'sd0, 32'sd0, -32'sd1);
        put_fields(KIND_COMPUTE, 0, 16'sd0, 32'sd0, 32'sh7fff_ffff);
        put_fields(KIND_READ_C, int'(tile_pos) - 1, 16'sd0, 32'sd0, 32'sd0);
        drain();
        write_mode(MODE_SPARE);
        put_fields(KIND_COMPUTE, 0, 16'sd0, 32'sd0, 32'sh8000_0000);
        drain();

        // random phases, one mode each
        foreach (phase_modes[p])
        begin
            write_mode(phase_modes[p]);
            n = 0;
            while (n < PHASE_BEATS)
            begin
                random_beat(counted);
                if (counted)
                    n++;
            end
            drain();
        end

        if (fail_count == 0 && pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
